// ----- rtl/core/pbd_pkg.sv -----
// ----------------------------------------------------------------------------
// pbd_pkg
// shared widths, constants, types and state codes of the bucket dispatcher
// ----------------------------------------------------------------------------
package pbd_pkg;

   localparam int PBD_NUM_LEVELS  = 11;
   localparam int PBD_MAX_PENDING = 64;

   localparam int HANDLE_W    = 10;
   localparam int PRIO_W      = 8;
   localparam int COUNT_W     = 7;
   // level codes are carried at the width of the largest legal level count (16)
   localparam int LEVEL_W     = 4;
   localparam int QUEUE_DEPTH = 2;

   // one classified word passed from the front to the back
   typedef struct packed {
      logic [HANDLE_W-1:0] handle_id;
      logic                has_handle;
      logic [LEVEL_W-1:0]  level;
      logic [COUNT_W-1:0]  active_limit;
      logic [COUNT_W-1:0]  prior_count;
      logic                set_dirty;
      logic                batch_end;
   } pbd_word_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_START,
      ST_WALK,
      ST_EMIT
   } pbd_state_type;

endpackage

// ----- rtl/core/priority_bucket_dispatcher_unit.sv -----
// ----------------------------------------------------------------------------
// priority_bucket_dispatcher_unit
// bucket priority queue: loads a batch of handles, dispatches by level
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per handle with its priority; the word with
//     req_batch_end set closes the batch and carries the limit, the prior
//     count and the set-dirty flag
//   rsp channel: one word per dispatched handle, highest level first and in
//     arrival order within a level, or one empty word; rsp_last_result marks
//     the final word of the batch
//   loading takes one word per cycle while the queue is not full; a word
//     passes the front in the cycle it is accepted and reaches the buckets
//     through a two-entry queue
//   the first dispatch word is registered via ST_START, ST_WALK and ST_EMIT
//     after the batch end word leaves the queue, an empty word via ST_START;
//     then one result per cycle within a level unless rsp stalls, plus an
//     ST_WALK pass per level (linked-list walk, one ram read per handle)
//   new words are taken into the queue during the walk until it fills
//   reset empties the queue and the buckets; no clearing pass is needed
//   a stalled rsp word holds, and the walk pauses until it is taken
// ----------------------------------------------------------------------------
module priority_bucket_dispatcher_unit #(
   parameter int NUM_LEVELS  = pbd_pkg::PBD_NUM_LEVELS,
   parameter int MAX_PENDING = pbd_pkg::PBD_MAX_PENDING
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pbd_pkg::HANDLE_W-1:0]      req_handle_id,
   input  logic                              req_has_handle,
   input  logic signed [pbd_pkg::PRIO_W-1:0] req_priority_req,
   input  logic [pbd_pkg::COUNT_W-1:0]       req_active_limit,
   input  logic [pbd_pkg::COUNT_W-1:0]       req_prior_count,
   input  logic                              req_set_dirty,
   input  logic                              req_batch_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pbd_pkg::HANDLE_W-1:0]      rsp_out_handle,
   output logic                              rsp_out_valid,
   output logic [pbd_pkg::COUNT_W-1:0]       rsp_total_count,
   output logic                              rsp_status,
   output logic                              rsp_last_result
);
   import pbd_pkg::*;

   // front to queue
   logic         push;
   logic         q_full;
   pbd_word_type push_word;

   // queue to back
   logic         q_pop;
   logic         q_valid;
   pbd_word_type q_word;

   // accept and clamp priority to a level
   pbd_front #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_handle_id     (req_handle_id),
      .req_has_handle    (req_has_handle),
      .req_priority_req  (req_priority_req),
      .req_active_limit  (req_active_limit),
      .req_prior_count   (req_prior_count),
      .req_set_dirty     (req_set_dirty),
      .req_batch_end     (req_batch_end),
      .q_full            (q_full),
      .q_push            (push),
      .q_word            (push_word)
   );

   // decouples loading from the dispatch walk
   pbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_word  (q_word)
   );

   // buckets, walk and result register
   pbd_back #(
      .NUM_LEVELS  (NUM_LEVELS),
      .MAX_PENDING (MAX_PENDING)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_word          (q_word),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_handle  (rsp_out_handle),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_total_count (rsp_total_count),
      .rsp_status      (rsp_status),
      .rsp_last_result (rsp_last_result)
   );

endmodule

// ----- rtl/core/pbd_ram.sv -----
// ----------------------------------------------------------------------------
// pbd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module pbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pbd_front.sv -----
// ----------------------------------------------------------------------------
// pbd_front
// accepts request words and clamps the priority to a bucket level
// ----------------------------------------------------------------------------
module pbd_front #(
   parameter int NUM_LEVELS = pbd_pkg::PBD_NUM_LEVELS
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pbd_pkg::HANDLE_W-1:0] req_handle_id,
   input  logic                         req_has_handle,
   input  logic signed [pbd_pkg::PRIO_W-1:0] req_priority_req,
   input  logic [pbd_pkg::COUNT_W-1:0]  req_active_limit,
   input  logic [pbd_pkg::COUNT_W-1:0]  req_prior_count,
   input  logic                         req_set_dirty,
   input  logic                         req_batch_end,
   input  logic                         q_full,
   output logic                         q_push,
   output pbd_pkg::pbd_word_type        q_word
);
   import pbd_pkg::*;

   logic in_range;

   // out of range (negative or past the top level) falls to the lowest level
   assign in_range = !req_priority_req[PRIO_W-1] &&
                     (req_priority_req < PRIO_W'(NUM_LEVELS));

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_word.handle_id     = req_handle_id;
      q_word.has_handle    = req_has_handle;
      q_word.level         = in_range ? req_priority_req[LEVEL_W-1:0] : '0;
      q_word.active_limit  = req_active_limit;
      q_word.prior_count   = req_prior_count;
      q_word.set_dirty     = req_set_dirty;
      q_word.batch_end     = req_batch_end;
   end

endmodule

// ----- rtl/core/pbd_queue.sv -----
// ----------------------------------------------------------------------------
// pbd_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module pbd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pbd_pkg::pbd_word_type push_word,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output pbd_pkg::pbd_word_type pop_word
);
   import pbd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pbd_word_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_word  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- rtl/core/pbd_back.sv -----
// ----------------------------------------------------------------------------
// pbd_back
// per-level linked buckets, dispatch walk and result register
// ----------------------------------------------------------------------------
module pbd_back #(
   parameter int NUM_LEVELS  = pbd_pkg::PBD_NUM_LEVELS,
   parameter int MAX_PENDING = pbd_pkg::PBD_MAX_PENDING
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  pbd_pkg::pbd_word_type        q_word,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pbd_pkg::HANDLE_W-1:0] rsp_out_handle,
   output logic                         rsp_out_valid,
   output logic [pbd_pkg::COUNT_W-1:0]  rsp_total_count,
   output logic                         rsp_status,
   output logic                         rsp_last_result
);
   import pbd_pkg::*;

   localparam int LVL_W = $clog2(NUM_LEVELS);
   localparam int IDX_W = $clog2(MAX_PENDING);
   localparam int CNT_W = $clog2(MAX_PENDING + 1);

   pbd_state_type         state_ff, state_in;
   logic [NUM_LEVELS-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]      entry_count_ff, entry_count_in;
   logic [COUNT_W-1:0]    limit_ff, limit_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  changed_ff, changed_in;
   logic [IDX_W-1:0]      cur_ptr_ff, cur_ptr_in;
   logic [LVL_W-1:0]      cur_lvl_ff, cur_lvl_in;
   logic [IDX_W-1:0]      head_ff [NUM_LEVELS];
   logic [IDX_W-1:0]      tail_ff [NUM_LEVELS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]   out_handle_ff, out_handle_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0]    out_count_ff, out_count_in;
   logic                  out_status_ff, out_status_in;
   logic                  out_last_ff, out_last_in;

   logic [LVL_W-1:0]      wr_lvl;
   logic [IDX_W-1:0]      new_idx;
   logic [LVL_W-1:0]      tail_sel;
   logic [IDX_W-1:0]      tail_rd;
   logic [LVL_W-1:0]      top_lvl;
   logic                  store_en, link_en, head_en;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [HANDLE_W-1:0]   handle_rd;
   logic [IDX_W-1:0]      next_rd;
   logic                  out_free, load_out, finish;
   logic                  dispatch, at_tail, last;
   logic [COUNT_W-1:0]    count_next;

   assign wr_lvl   = q_word.level[LVL_W-1:0];
   assign new_idx  = entry_count_ff[IDX_W-1:0];
   assign tail_rd  = tail_ff[tail_sel];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // highest non-empty bucket still to walk
   always_comb begin
      top_lvl = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (mask_ff[i]) begin
            top_lvl = LVL_W'(i);
         end
      end
   end

   assign dispatch   = (limit_ff != '0) && (mask_ff != '0) && !changed_ff &&
                       (count_ff < limit_ff);
   assign count_next = count_ff + 1'b1;
   assign at_tail    = (cur_ptr_ff == tail_rd);
   assign last       = (count_next >= limit_ff) || (at_tail && (mask_ff == '0));

   always_comb begin
      state_in       = state_ff;
      mask_in        = mask_ff;
      entry_count_in = entry_count_ff;
      limit_in       = limit_ff;
      count_in       = count_ff;
      changed_in     = changed_ff;
      cur_ptr_in     = cur_ptr_ff;
      cur_lvl_in     = cur_lvl_ff;
      q_pop          = 1'b0;
      store_en       = 1'b0;
      link_en        = 1'b0;
      head_en        = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = cur_ptr_ff;
      tail_sel       = cur_lvl_ff;
      load_out       = 1'b0;
      finish         = 1'b0;
      out_handle_in  = '0;
      out_valid_in   = 1'b0;
      out_count_in   = count_ff;
      out_status_in  = 1'b0;
      out_last_in    = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            tail_sel = wr_lvl;
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_word.has_handle && (entry_count_ff < CNT_W'(MAX_PENDING))) begin
                  store_en        = 1'b1;
                  entry_count_in  = entry_count_ff + 1'b1;
                  mask_in[wr_lvl] = 1'b1;
                  if (mask_ff[wr_lvl]) begin
                     link_en = 1'b1;
                  end else begin
                     head_en = 1'b1;
                  end
               end
               if (q_word.batch_end) begin
                  limit_in   = q_word.active_limit;
                  count_in   = q_word.prior_count;
                  changed_in = q_word.set_dirty;
                  state_in   = ST_START;
               end
            end
         end
         ST_START: begin
            if (dispatch) begin
               state_in = ST_WALK;
            end else if (out_free) begin
               // single empty word for the batch
               load_out      = 1'b1;
               out_status_in = (limit_ff != '0) && changed_ff && (count_ff != '0);
               out_last_in   = 1'b1;
               finish        = 1'b1;
            end
         end
         ST_WALK: begin
            rd_en            = 1'b1;
            rd_addr          = head_ff[top_lvl];
            cur_ptr_in       = head_ff[top_lvl];
            cur_lvl_in       = top_lvl;
            mask_in[top_lvl] = 1'b0;
            state_in         = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out      = 1'b1;
               out_handle_in = handle_rd;
               out_valid_in  = 1'b1;
               out_count_in  = count_next;
               out_last_in   = last;
               count_in      = count_next;
               if (last) begin
                  finish = 1'b1;
               end else if (at_tail) begin
                  state_in = ST_WALK;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = next_rd;
                  cur_ptr_in = next_rd;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      if (finish) begin
         mask_in        = '0;
         entry_count_in = '0;
         state_in       = ST_LOAD;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         mask_ff        <= '0;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mask_ff        <= mask_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff   <= limit_in;
      count_ff   <= count_in;
      changed_ff <= changed_in;
      cur_ptr_ff <= cur_ptr_in;
      cur_lvl_ff <= cur_lvl_in;
      if (store_en) begin
         tail_ff[wr_lvl] <= new_idx;
      end
      if (head_en) begin
         head_ff[wr_lvl] <= new_idx;
      end
      if (load_out) begin
         out_handle_ff <= out_handle_in;
         out_valid_ff  <= out_valid_in;
         out_count_ff  <= out_count_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

   pbd_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (MAX_PENDING)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (new_idx),
      .wr_data (q_word.handle_id),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (handle_rd)
   );

   // link from the old tail of a level to the newly stored entry
   pbd_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_PENDING)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (link_en),
      .wr_addr (tail_rd),
      .wr_data (new_idx),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_handle  = out_handle_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_total_count = out_count_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last_result = out_last_ff;

endmodule
